>>> rtl/core/irp_pkg.sv
package irp_pkg;

  localparam int CPU_COUNT = 8;
  localparam int CPU_AW    = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;

  localparam int AVG_W   = 41;
  localparam int TIME_W  = 64;
  localparam int RES_W   = 32;
  localparam int SHIFT_W = 4;
  localparam int US_W    = 20;
  localparam int NS_W    = 30;
  localparam int ACC_W   = AVG_W + (1 << SHIFT_W);

  localparam int NS_PER_US = 1000;

  localparam int RST_SHIFT    = 3;
  localparam int RST_FORCE_US = 2000;
  localparam int RST_MIN_US   = 200;
  localparam int RST_COAL_US  = 800;

  localparam logic [1:0] OP_DECIDE = 2'd0;
  localparam logic [1:0] OP_EXIT   = 2'd1;
  localparam logic [1:0] OP_WAKE   = 2'd2;

  localparam logic [1:0] CFG_EWMA_SHIFT  = 2'd0;
  localparam logic [1:0] CFG_FORCE_STOP  = 2'd1;
  localparam logic [1:0] CFG_MIN_SAMPLE  = 2'd2;
  localparam logic [1:0] CFG_WAKE_COAL   = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_WRITE
  } st_t;

  typedef struct packed {
    logic [SHIFT_W-1:0] shift;
    logic [NS_W-1:0]    force_ns;
    logic [NS_W-1:0]    min_ns;
    logic [NS_W-1:0]    coal_ns;
  } irp_cfg_t;

  typedef struct packed {
    logic               en;
    logic               we_avg;
    logic               we_wake;
    logic [CPU_AW-1:0]  addr;
    logic [AVG_W-1:0]   avg_wdata;
    logic [TIME_W-1:0]  wake_wdata;
  } irp_mem_req_t;

endpackage

>>> rtl/core/irp_in_if.sv
interface irp_in_if import irp_pkg::*; ;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic [2:0]         cpu_index;
  logic [TIME_W-1:0]  time_now_ns;
  logic signed [RES_W-1:0] residency_us;
  logic               governor_stop_hint;
  logic               tick_already_stopped;

  modport source (
    output valid, operation, cpu_index, time_now_ns, residency_us,
           governor_stop_hint, tick_already_stopped,
    input  ready
  );
  modport sink (
    input  valid, operation, cpu_index, time_now_ns, residency_us,
           governor_stop_hint, tick_already_stopped,
    output ready
  );
endinterface

>>> rtl/core/irp_out_if.sv
interface irp_out_if import irp_pkg::*; ;
  logic             valid;
  logic             ready;
  logic             halt_tick;
  logic             forced;
  logic [AVG_W-1:0] est_idle_ns;

  modport source (output valid, halt_tick, forced, est_idle_ns, input ready);
  modport sink (input valid, halt_tick, forced, est_idle_ns, output ready);
endinterface

>>> rtl/core/irp_cfg_if.sv
interface irp_cfg_if import irp_pkg::*; ;
  logic            valid;
  logic            ready;
  logic [1:0]      index;
  logic [US_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/core/irp_ram.sv
module irp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (en) begin
      rdata <= mem[addr];
    end
  end

endmodule

>>> rtl/core/irp_cfg_regs.sv
module irp_cfg_regs import irp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  irp_cfg_if.sink   cfg_ch,
  output irp_cfg_t  cfg
);

  irp_cfg_t cfg_r, cfg_nxt;
  logic     wr;

  assign cfg_ch.ready = 1'b1;
  assign wr = cfg_ch.valid;

  // thresholds are kept in ns so the datapath never multiplies them
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      case (cfg_ch.index)
        CFG_EWMA_SHIFT: cfg_nxt.shift    = cfg_ch.data[SHIFT_W-1:0];
        CFG_FORCE_STOP: cfg_nxt.force_ns = NS_W'(cfg_ch.data) * NS_W'(NS_PER_US);
        CFG_MIN_SAMPLE: cfg_nxt.min_ns   = NS_W'(cfg_ch.data) * NS_W'(NS_PER_US);
        CFG_WAKE_COAL:  cfg_nxt.coal_ns  = NS_W'(cfg_ch.data) * NS_W'(NS_PER_US);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.shift    <= SHIFT_W'(RST_SHIFT);
      cfg_r.force_ns <= NS_W'(RST_FORCE_US * NS_PER_US);
      cfg_r.min_ns   <= NS_W'(RST_MIN_US * NS_PER_US);
      cfg_r.coal_ns  <= NS_W'(RST_COAL_US * NS_PER_US);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> rtl/core/irp_core.sv
module irp_core import irp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  irp_cfg_t          cfg,
  irp_in_if.sink            in_ch,
  irp_out_if.source         out_ch,
  output irp_mem_req_t      mem_req,
  input  logic [AVG_W-1:0]  avg_rdata,
  input  logic [TIME_W-1:0] wake_rdata
);

  st_t state_r, state_nxt;

  logic in_fire, out_load;

  logic [1:0]         op_r;
  logic [CPU_AW-1:0]  addr_r;
  logic               in_range_r;
  logic [TIME_W-1:0]  now_r;
  logic [RES_W-1:0]   res_r;
  logic               hint_r, stopped_r;

  logic [AVG_W-1:0]   prev_r;
  logic [AVG_W-1:0]   sample_r;
  logic               forced_r;

  logic [CPU_COUNT-1:0] avg_vld_r, avg_vld_nxt;
  logic [CPU_COUNT-1:0] wake_vld_r, wake_vld_nxt;

  logic               out_valid_r, out_stop_r, out_forced_r;
  logic [AVG_W-1:0]   out_pred_r;

  logic [AVG_W-1:0]   prev_c;
  logic [TIME_W-1:0]  last_c;
  logic [TIME_W-1:0]  age_c;
  logic               forced_c;
  logic [AVG_W-1:0]   sample_c;

  logic [AVG_W-1:0]   samp_eff;
  logic [ACC_W-1:0]   acc;
  logic [ACC_W-1:0]   shifted;
  logic [AVG_W-1:0]   avg_new;
  logic               do_exit, do_wake;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_ch.valid) state_nxt = ST_CALC;
      ST_CALC:  state_nxt = ST_WRITE;
      ST_WRITE: if (!out_valid_r || out_ch.ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_ch.ready = 1'b0;
    out_load    = 1'b0;
    case (state_r)
      ST_IDLE:  in_ch.ready = 1'b1;
      ST_CALC:  ;
      ST_WRITE: out_load = !out_valid_r || out_ch.ready;
      default:  ;
    endcase
  end

  assign in_fire = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r       <= in_ch.operation;
      addr_r     <= CPU_AW'(in_ch.cpu_index);
      in_range_r <= 32'(in_ch.cpu_index) < CPU_COUNT;
      now_r      <= in_ch.time_now_ns;
      res_r      <= in_ch.residency_us;
      hint_r     <= in_ch.governor_stop_hint;
      stopped_r  <= in_ch.tick_already_stopped;
    end
  end

  // calc stage: entries never written read as zero
  assign prev_c = avg_vld_r[addr_r] ? avg_rdata : '0;
  assign last_c = wake_vld_r[addr_r] ? wake_rdata : '0;
  assign age_c  = now_r - last_c;

  assign forced_c = (prev_c != '0) && (prev_c >= AVG_W'(cfg.force_ns)) &&
                    ((last_c == '0) || (age_c >= TIME_W'(cfg.coal_ns)));

  assign sample_c = (!res_r[RES_W-1] && (res_r != '0)) ?
                    AVG_W'(AVG_W'(res_r[RES_W-2:0]) * AVG_W'(NS_PER_US)) : '0;

  always_ff @(posedge clk) begin
    if (state_r == ST_CALC) begin
      prev_r   <= prev_c;
      sample_r <= sample_c;
      forced_r <= forced_c && (op_r == OP_DECIDE);
    end
  end

  // write stage: ((2^s-1)*prev + sample) >> s
  assign samp_eff = (sample_r < AVG_W'(cfg.min_ns)) ? '0 : sample_r;
  assign acc      = (ACC_W'(prev_r) << cfg.shift) - ACC_W'(prev_r) + ACC_W'(samp_eff);
  assign shifted  = acc >> cfg.shift;

  always_comb begin
    if (cfg.shift == '0) begin
      avg_new = samp_eff;
    end else if (shifted == '0 && samp_eff != '0) begin
      avg_new = AVG_W'(1);
    end else begin
      avg_new = shifted[AVG_W-1:0];
    end
  end

  assign do_exit = out_load && in_range_r && (op_r == OP_EXIT);
  assign do_wake = out_load && in_range_r && ((op_r == OP_EXIT) || (op_r == OP_WAKE));

  always_comb begin
    mem_req.en         = in_fire;
    mem_req.we_avg     = do_exit;
    mem_req.we_wake    = do_wake;
    mem_req.addr       = in_fire ? CPU_AW'(in_ch.cpu_index) : addr_r;
    mem_req.avg_wdata  = avg_new;
    mem_req.wake_wdata = now_r;
  end

  always_comb begin
    avg_vld_nxt  = avg_vld_r;
    wake_vld_nxt = wake_vld_r;
    if (do_exit) avg_vld_nxt[addr_r] = 1'b1;
    if (do_wake) wake_vld_nxt[addr_r] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_vld_r  <= '0;
      wake_vld_r <= '0;
    end else begin
      avg_vld_r  <= avg_vld_nxt;
      wake_vld_r <= wake_vld_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (!in_range_r) begin
        out_stop_r   <= 1'b0;
        out_forced_r <= 1'b0;
        out_pred_r   <= '0;
      end else begin
        out_stop_r   <= (op_r == OP_DECIDE) && (hint_r || forced_r || stopped_r);
        out_forced_r <= forced_r;
        out_pred_r   <= (op_r == OP_EXIT) ? avg_new : prev_r;
      end
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.halt_tick   = out_stop_r;
  assign out_ch.forced      = out_forced_r;
  assign out_ch.est_idle_ns = out_pred_r;

  a_write_in_wb: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_req.we_avg || mem_req.we_wake) |-> (state_r == ST_WRITE))
    else $error("store written outside write-back");

  a_fire_to_calc: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_CALC))
    else $error("accepted transaction did not enter calc");

  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r)
    else $error("result load lost");

  a_stop_decide_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && (op_r != OP_DECIDE)) |=> (!out_stop_r && !out_forced_r))
    else $error("stop flags set on non-decide transaction");

endmodule

>>> rtl/core/idle_residency_predictor.sv
// each input transaction passes read, calc and write-back before its result is valid
// a new transaction is taken only once the previous one is written back, set by the single-port
//   read-modify-write of the per-cpu entry (read at accept, calc, write-back with result load)
// reset (synchronous, rst_n low): config returns to shift 3, 2000/200/800 us,
//   per-entry valid flops clear at once so both stores read as zero, no clearing pass
module idle_residency_predictor import irp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  irp_in_if.sink     in_ch,
  irp_out_if.source  out_ch,
  irp_cfg_if.sink    cfg_ch
);

  irp_cfg_t          cfg;
  irp_mem_req_t      mem_req;
  logic [AVG_W-1:0]  avg_rdata;
  logic [TIME_W-1:0] wake_rdata;

  // config registers, thresholds held pre-scaled to ns
  irp_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  // per-cpu ewma store
  irp_ram #(.WIDTH(AVG_W), .DEPTH(CPU_COUNT)) u_avg_ram (
    .clk   (clk),
    .en    (mem_req.en),
    .we    (mem_req.we_avg),
    .addr  (mem_req.addr),
    .wdata (mem_req.avg_wdata),
    .rdata (avg_rdata)
  );

  // per-cpu last wakeup store, zero means never
  irp_ram #(.WIDTH(TIME_W), .DEPTH(CPU_COUNT)) u_wake_ram (
    .clk   (clk),
    .en    (mem_req.en),
    .we    (mem_req.we_wake),
    .addr  (mem_req.addr),
    .wdata (mem_req.wake_wdata),
    .rdata (wake_rdata)
  );

  // sequencer and datapath: decide compare, ewma update, result register
  irp_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .mem_req    (mem_req),
    .avg_rdata  (avg_rdata),
    .wake_rdata (wake_rdata)
  );

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import irp_pkg::*;

  // operation code the block leaves unused
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_EVENTS = 90;

  typedef struct packed {
    logic [1:0]        op;
    logic [2:0]        cpu;
    logic [TIME_W-1:0] now_ns;
    logic [RES_W-1:0]  res_us;
    logic              hint;
    logic              stopped;
  } idle_event_t;

  typedef struct packed {
    logic             halt_tick;
    logic             forced;
    logic [AVG_W-1:0] est_idle_ns;
  } tick_result_t;

  typedef struct packed {
    logic [SHIFT_W-1:0] shift;
    logic [US_W-1:0]    force_us;
    logic [US_W-1:0]    min_us;
    logic [US_W-1:0]    coal_us;
  } threshold_set_t;

  logic clk;
  logic rst_n;

  irp_in_if  in_ch();
  irp_out_if out_ch();
  irp_cfg_if cfg_ch();

  idle_residency_predictor dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // predictor state: per-cpu average and last wakeup, plus a mirror of the registers
  logic [AVG_W-1:0]   avg_ns_model [CPU_COUNT];
  logic [TIME_W-1:0]  last_wake_model [CPU_COUNT];
  logic [SHIFT_W-1:0] shift_cfg;
  logic [US_W-1:0]    force_us_cfg;
  logic [US_W-1:0]    min_us_cfg;
  logic [US_W-1:0]    coal_us_cfg;

  idle_event_t  pending_events[$];
  tick_result_t expected_results[$];
  idle_event_t  on_bus;

  int unsigned events_queued;
  int unsigned events_accepted;
  int unsigned mismatches;
  int unsigned cycle_count;
  int unsigned in_gap;
  int unsigned out_hold;
  int unsigned in_idle_pct;
  int unsigned out_idle_pct;
  logic [TIME_W-1:0] stim_now_ns;

  function automatic logic [63:0] us_to_ns(input logic [US_W-1:0] us);
    return 64'(us) * 64'(NS_PER_US);
  endfunction

  // advance the per-cpu model by one transaction and return what the block should answer
  function automatic tick_result_t apply_idle_event(input idle_event_t ev);
    tick_result_t r;
    logic [63:0]  sample;
    logic [63:0]  blended;
    logic [63:0]  age;
    r = '0;
    // unsigned difference, so a clock that went backwards wraps to a huge age
    age = ev.now_ns - last_wake_model[ev.cpu];
    case (ev.op)
      OP_DECIDE: begin
        r.forced = (avg_ns_model[ev.cpu] != '0) &&
                   (64'(avg_ns_model[ev.cpu]) >= us_to_ns(force_us_cfg)) &&
                   (last_wake_model[ev.cpu] == '0 || age >= us_to_ns(coal_us_cfg));
        r.halt_tick = ev.hint | r.forced | ev.stopped;
      end
      OP_EXIT: begin
        if (!ev.res_us[RES_W-1] && ev.res_us != '0) begin
          sample = 64'(ev.res_us) * 64'(NS_PER_US);
        end else begin
          sample = '0;
        end
        if (sample < us_to_ns(min_us_cfg)) sample = '0;
        if (shift_cfg == '0) begin
          blended = sample;
        end else begin
          blended = (64'(avg_ns_model[ev.cpu]) * ((64'd1 << shift_cfg) - 64'd1) + sample)
                    >> shift_cfg;
          // a nonzero sample never leaves the average at zero
          if (blended == '0 && sample != '0) blended = 64'd1;
        end
        avg_ns_model[ev.cpu] = blended[AVG_W-1:0];
        last_wake_model[ev.cpu] = ev.now_ns;
      end
      OP_WAKE: begin
        last_wake_model[ev.cpu] = ev.now_ns;
      end
      default: begin
        // unused code leaves both stores alone
      end
    endcase
    r.est_idle_ns = avg_ns_model[ev.cpu];
    return r;
  endfunction

  function automatic idle_event_t idle_event(input logic [1:0] op, input logic [2:0] cpu,
                                             input logic [TIME_W-1:0] now_ns,
                                             input logic [RES_W-1:0] res_us,
                                             input logic hint, input logic stopped);
    idle_event_t ev;
    ev.op = op;
    ev.cpu = cpu;
    ev.now_ns = now_ns;
    ev.res_us = res_us;
    ev.hint = hint;
    ev.stopped = stopped;
    return ev;
  endfunction

  // random transaction around the current thresholds, on a mostly forward-running clock
  function automatic idle_event_t random_idle_event();
    idle_event_t ev;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) ev.op = OP_DECIDE;
    else if (pick < 80) ev.op = OP_EXIT;
    else if (pick < 94) ev.op = OP_WAKE;
    else ev.op = OP_UNUSED;
    ev.cpu = 3'($urandom_range(0, CPU_COUNT - 1));
    pick = $urandom_range(0, 99);
    if (pick < 85) begin
      stim_now_ns += 64'($urandom_range(0, coal_us_cfg / 2 + 2)) * 64'(NS_PER_US) +
                     64'($urandom_range(0, 999));
    end else if (pick < 90) begin
      stim_now_ns -= 64'($urandom_range(1, 2000000));
    end else if (pick < 96) begin
      stim_now_ns = {$urandom, $urandom};
    end else begin
      stim_now_ns = '0;
    end
    ev.now_ns = stim_now_ns;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      ev.res_us = RES_W'($urandom_range(0, 2 * force_us_cfg + 2 * min_us_cfg + 16));
    end else if (pick < 80) begin
      // straddle the minimum sample
      ev.res_us = RES_W'(min_us_cfg) + RES_W'($urandom_range(0, 2)) - RES_W'(1);
    end else if (pick < 90) begin
      ev.res_us = $urandom;
    end else if (pick < 95) begin
      ev.res_us = '0;
    end else begin
      ev.res_us = RES_W'($urandom_range(1, 16));
    end
    ev.hint = 1'($urandom_range(0, 1));
    ev.stopped = 1'($urandom_range(0, 1));
    return ev;
  endfunction

  task automatic queue_event(input idle_event_t ev);
    pending_events.push_back(ev);
    events_queued++;
  endtask

  // block is idle once every transaction went in and every result came out
  task automatic wait_until_drained();
    @(posedge clk);
    while (events_accepted != events_queued || expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg_reg(input logic [1:0] idx, input logic [US_W-1:0] value);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      CFG_EWMA_SHIFT: shift_cfg = value[SHIFT_W-1:0];
      CFG_FORCE_STOP: force_us_cfg = value;
      CFG_MIN_SAMPLE: min_us_cfg = value;
      CFG_WAKE_COAL:  coal_us_cfg = value;
      default: ;
    endcase
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic program_thresholds(input threshold_set_t s);
    write_cfg_reg(CFG_EWMA_SHIFT, US_W'(s.shift));
    write_cfg_reg(CFG_FORCE_STOP, s.force_us);
    write_cfg_reg(CFG_MIN_SAMPLE, s.min_us);
    write_cfg_reg(CFG_WAKE_COAL, s.coal_us);
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // input driver: one transaction on the bus, next one loaded once the current is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_gap <= 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) begin
        expected_results.push_back(apply_idle_event(on_bus));
        events_accepted++;
      end
      if (in_gap != 0) begin
        in_ch.valid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (pending_events.size() != 0 && $urandom_range(0, 99) < in_idle_pct) begin
        // random idle burst on the input
        in_ch.valid <= 1'b0;
        in_gap <= $urandom_range(0, 3);
      end else if (pending_events.size() != 0) begin
        on_bus = pending_events.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.operation <= on_bus.op;
        in_ch.cpu_index <= on_bus.cpu;
        in_ch.time_now_ns <= on_bus.now_ns;
        in_ch.residency_us <= on_bus.res_us;
        in_ch.governor_stop_hint <= on_bus.hint;
        in_ch.tick_already_stopped <= on_bus.stopped;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result monitor: compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    tick_result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_hold <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, got halt %0b forced %0b est %0d",
                   $time, out_ch.halt_tick, out_ch.forced, out_ch.est_idle_ns);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (out_ch.halt_tick !== want.halt_tick) begin
            $display("%0t: halt_tick expected %0b got %0b", $time, want.halt_tick,
                     out_ch.halt_tick);
            mismatches++;
          end
          if (out_ch.forced !== want.forced) begin
            $display("%0t: forced expected %0b got %0b", $time, want.forced, out_ch.forced);
            mismatches++;
          end
          if (out_ch.est_idle_ns !== want.est_idle_ns) begin
            $display("%0t: est_idle_ns expected %0d got %0d", $time, want.est_idle_ns,
                     out_ch.est_idle_ns);
            mismatches++;
          end
        end
      end
      // backpressure in random bursts
      if (out_hold != 0) begin
        out_ch.ready <= 1'b0;
        out_hold <= out_hold - 1;
      end else if ($urandom_range(0, 99) < out_idle_pct) begin
        out_ch.ready <= 1'b0;
        out_hold <= $urandom_range(0, 3);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    threshold_set_t plan [6];
    int unsigned    ph;
    int unsigned    n;

    // low extremes: zero threshold forces on any nonzero average
    plan[0] = '{4'd0, 20'd0, 20'd0, 20'd0};
    // high extremes
    plan[1] = '{4'd15, 20'd1000000, 20'd1000000, 20'd1000000};
    // slow average with no minimum, where small samples hit the floor of one
    plan[2] = '{4'd15, 20'd1, 20'd0, 20'd1};
    plan[3] = '{4'd1, 20'd50, 20'd10, 20'd30};
    plan[4] = '{4'($urandom_range(1, 14)), 20'($urandom_range(1, 5000)),
                20'($urandom_range(1, 1000)), 20'($urandom_range(1, 3000))};
    // back to the reset thresholds for the quiet tail
    plan[5] = '{4'(RST_SHIFT), 20'(RST_FORCE_US), 20'(RST_MIN_US), 20'(RST_COAL_US)};

    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.operation = OP_DECIDE;
    in_ch.cpu_index = '0;
    in_ch.time_now_ns = '0;
    in_ch.residency_us = '0;
    in_ch.governor_stop_hint = 1'b0;
    in_ch.tick_already_stopped = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_EWMA_SHIFT;
    cfg_ch.data = '0;
    in_idle_pct = 0;
    out_idle_pct = 0;
    events_queued = 0;
    events_accepted = 0;
    mismatches = 0;
    cycle_count = 0;
    stim_now_ns = '0;
    for (int i = 0; i < CPU_COUNT; i++) begin
      avg_ns_model[i] = '0;
      last_wake_model[i] = '0;
    end
    shift_cfg = SHIFT_W'(RST_SHIFT);
    force_us_cfg = US_W'(RST_FORCE_US);
    min_us_cfg = US_W'(RST_MIN_US);
    coal_us_cfg = US_W'(RST_COAL_US);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    in_idle_pct <= 20;
    out_idle_pct <= 20;

    // directed part, reset thresholds: 2000 us force, 200 us minimum, 800 us window
    queue_event(idle_event(OP_DECIDE, 3'd0, 64'd0, 32'd0, 1'b1, 1'b0));
    queue_event(idle_event(OP_DECIDE, 3'd1, '1, 32'h8000_0000, 1'b0, 1'b1));
    queue_event(idle_event(OP_UNUSED, 3'd0, 64'd123, 32'h7fff_ffff, 1'b1, 1'b1));
    // largest residency drives the average far above the threshold
    queue_event(idle_event(OP_EXIT, 3'd2, 64'd1000, 32'h7fff_ffff, 1'b0, 1'b0));
    // one ns short of the wakeup window, then exactly on it
    queue_event(idle_event(OP_DECIDE, 3'd2, 64'd800999, 32'd0, 1'b0, 1'b0));
    queue_event(idle_event(OP_DECIDE, 3'd2, 64'd801000, 32'd0, 1'b0, 1'b0));
    queue_event(idle_event(OP_UNUSED, 3'd2, 64'd5, 32'd9, 1'b0, 1'b1));
    // most negative residency counts as no sample, and time zero reads as never
    queue_event(idle_event(OP_EXIT, 3'd3, 64'd0, 32'h8000_0000, 1'b0, 1'b0));
    queue_event(idle_event(OP_EXIT, 3'd3, 64'd7, 32'd0, 1'b1, 1'b0));
    // just below and at the minimum sample
    queue_event(idle_event(OP_EXIT, 3'd4, 64'd500, 32'd199, 1'b0, 1'b0));
    queue_event(idle_event(OP_EXIT, 3'd4, 64'd600, 32'd200, 1'b0, 1'b0));
    queue_event(idle_event(OP_DECIDE, 3'd4, 64'd10000000, 32'd0, 1'b0, 1'b0));
    // wakeup recorded at time zero leaves the cpu as never woken
    queue_event(idle_event(OP_EXIT, 3'd5, 64'd2000, 32'd100000, 1'b0, 1'b0));
    queue_event(idle_event(OP_WAKE, 3'd5, 64'd0, 32'hffff_ffff, 1'b1, 1'b1));
    queue_event(idle_event(OP_DECIDE, 3'd5, 64'd1, 32'd0, 1'b0, 1'b0));
    // clock running backwards wraps the age
    queue_event(idle_event(OP_EXIT, 3'd6, 64'd1000000000, 32'd1000000, 1'b0, 1'b0));
    queue_event(idle_event(OP_DECIDE, 3'd6, 64'd999999999, 32'd0, 1'b0, 1'b0));
    queue_event(idle_event(OP_WAKE, 3'd7, '1, 32'd0, 1'b0, 1'b0));
    queue_event(idle_event(OP_EXIT, 3'd7, '1, 32'hffff_ffff, 1'b1, 1'b1));
    queue_event(idle_event(OP_DECIDE, 3'd7, 64'd5, 32'd0, 1'b0, 1'b0));
    queue_event(idle_event(OP_EXIT, 3'd1, 64'h8000_0000_0000_0000, 32'h7fff_ffff, 1'b1, 1'b1));

    for (n = 0; n < PHASE_EVENTS; n++) queue_event(random_idle_event());

    // random phases, thresholds only change with the block idle
    for (ph = 0; ph < 6; ph++) begin
      wait_until_drained();
      program_thresholds(plan[ph]);
      if (ph == 5) begin
        in_idle_pct <= 0;
        out_idle_pct <= 0;
      end else begin
        in_idle_pct <= $urandom_range(5, 40);
        out_idle_pct <= $urandom_range(5, 40);
      end
      for (n = 0; n < PHASE_EVENTS; n++) queue_event(random_idle_event());
    end

    wait_until_drained();
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
